// ===== src/line_to_frame_packetizer_defines.svh =====
// Assertion macros shared by the line-to-frame packetizer RTL.
// Depends on nothing; users must have signals named clock and reset in scope.
`ifndef LINE_TO_FRAME_PACKETIZER_DEFINES_SVH
`define LINE_TO_FRAME_PACKETIZER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define LFP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define LFP_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== src/lfp_pkg.sv =====
// Types and constants of the line-to-frame packetizer.
// Depends on nothing; used by the front, engine, emit and top modules.
package lfp_pkg;

   localparam logic [7:0] FRAME_START = 8'h7E;
   localparam logic [7:0] LINE_FEED   = 8'h0A;
   localparam logic [7:0] CHECK_BASE  = 8'hFF;
   localparam logic [15:0] LEN_HI_MASK = 16'hFF00;
   localparam int HEADER_END = 7;
   localparam int LEN_OFFSET = 5;
   localparam int HDR_FIRST  = 3;

   localparam int CFG_REGS  = 4;
   localparam int CFG_IW    = 2;
   localparam int FQ_DEPTH  = 4;
   localparam int FQ_AW     = 2;
   localparam int FQ_CW     = 3;

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_PULL = 1'b1;

   typedef enum logic [1:0] {
      ITEM_PUSH,
      ITEM_LF,
      ITEM_PULL
   } item_kind_type;

   typedef struct packed {
      item_kind_type kind;
      logic [7:0]    data;
   } queue_entry_type;

   typedef enum logic [2:0] {
      SEL_IMM,
      SEL_START,
      SEL_HDR,
      SEL_PAY,
      SEL_SUM
   } byte_sel_type;

   typedef struct packed {
      logic         valid;
      logic         ok;
      byte_sel_type sel;
      logic [7:0]   imm;
      logic         last;
      logic         dropped;
   } result_type;

endpackage

// ===== src/lfp_front.sv =====
// Front of the packetizer: accept items, classify them and queue them.
// Depends on lfp_pkg.
module lfp_front import lfp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  logic            req_opcode,
   input  logic [7:0]      req_rx_byte,
   output logic            q_valid,
   output queue_entry_type q_entry,
   input  logic            q_ready
);

   queue_entry_type        slots_ff [FQ_DEPTH];
   logic [FQ_AW-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [FQ_AW-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [FQ_CW-1:0]       count_ff, count_in;
   logic                   accept, keep, pop;
   queue_entry_type        classified;

   assign req_stall = (count_ff == FQ_CW'(FQ_DEPTH));
   assign accept    = req_valid && !req_stall;

   // Classify; pushed zero bytes are dropped here and never queued.
   always_comb begin
      classified.data = req_rx_byte;
      keep            = 1'b1;
      if (req_opcode == OP_PULL) begin
         classified.kind = ITEM_PULL;
      end else if (req_rx_byte == LINE_FEED) begin
         classified.kind = ITEM_LF;
      end else begin
         classified.kind = ITEM_PUSH;
         keep            = (req_rx_byte != 8'h00);
      end
   end

   assign q_valid = (count_ff != '0);
   assign q_entry = slots_ff[rd_ptr_ff];
   assign pop     = q_valid && q_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept && keep) begin
         wr_ptr_in = wr_ptr_ff + FQ_AW'(1);
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + FQ_AW'(1);
      end
      count_in = count_ff + FQ_CW'(accept && keep) - FQ_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && keep) begin
         slots_ff[wr_ptr_ff] <= classified;
      end
   end

endmodule

// ===== src/lfp_engine.sv =====
// Engine of the packetizer: line ring, length queue and frame sequencing.
// Depends on lfp_pkg and line_to_frame_packetizer_defines.svh.
`include "line_to_frame_packetizer_defines.svh"
module lfp_engine import lfp_pkg::*; #(
   parameter int RING_DEPTH = 512,
   parameter int LINE_SLOTS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  queue_entry_type                q_entry,
   output logic                           q_ready,
   input  logic [CFG_REGS-1:0][7:0]       cfg_regs,
   output result_type                     pend,
   output logic [7:0]                     mem_data,
   input  logic                           pend_take
);

   localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int LW = $clog2(RING_DEPTH + 1);
   localparam int FW = $clog2(RING_DEPTH + HEADER_END + 1);
   localparam int QW = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
   localparam int CW = $clog2(LINE_SLOTS + 1);

   logic [7:0]    ring_mem [RING_DEPTH];
   logic [7:0]    mem_data_ff;
   logic [LW-1:0] len_queue_ff [LINE_SLOTS];

   logic [AW-1:0] write_ptr_ff, write_ptr_in;
   logic [AW-1:0] read_ptr_ff, read_ptr_in;
   logic [AW-1:0] line_start_ff, line_start_in;
   logic [LW-1:0] fill_count_ff, fill_count_in;
   logic [LW-1:0] partial_len_ff, partial_len_in;
   logic [QW-1:0] queue_head_ff, queue_head_in;
   logic [QW-1:0] queue_tail_ff, queue_tail_in;
   logic [CW-1:0] queued_lines_ff, queued_lines_in;
   logic [FW-1:0] frame_pos_ff, frame_pos_in;
   logic          dropped_ff, dropped_in;
   logic          skip_line_ff, skip_line_in;
   result_type    pend_ff, pend_in;

   logic          fire, mem_we, mem_re, lq_we;
   logic          is_lf;
   logic [LW-1:0] cur_len, new_len;
   logic [15:0]   frame_len;
   logic [CFG_IW-1:0] cfg_idx;

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
      ring_next = (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
   endfunction

   function automatic logic [QW-1:0] slot_next(input logic [QW-1:0] p);
      slot_next = (p == QW'(LINE_SLOTS - 1)) ? '0 : p + QW'(1);
   endfunction

   assign q_ready   = !pend_ff.valid || pend_take;
   assign fire      = q_valid && q_ready;
   assign pend      = pend_ff;
   assign mem_data  = mem_data_ff;
   assign is_lf     = (q_entry.kind == ITEM_LF);
   assign cur_len   = len_queue_ff[queue_head_ff];
   assign new_len   = partial_len_ff + LW'(1);
   assign frame_len = 16'(cur_len) + 16'(LEN_OFFSET);
   assign cfg_idx   = CFG_IW'(frame_pos_ff - FW'(HDR_FIRST));

   always_comb begin
      write_ptr_in    = write_ptr_ff;
      read_ptr_in     = read_ptr_ff;
      line_start_in   = line_start_ff;
      fill_count_in   = fill_count_ff;
      partial_len_in  = partial_len_ff;
      queue_head_in   = queue_head_ff;
      queue_tail_in   = queue_tail_ff;
      queued_lines_in = queued_lines_ff;
      frame_pos_in    = frame_pos_ff;
      dropped_in      = dropped_ff;
      skip_line_in    = skip_line_ff;
      mem_we          = 1'b0;
      mem_re          = 1'b0;
      lq_we           = 1'b0;
      pend_in         = pend_ff;
      if (pend_take) begin
         pend_in.valid = 1'b0;
      end
      if (fire) begin
         pend_in = '0;
         unique case (q_entry.kind)
            ITEM_PUSH, ITEM_LF: begin
               priority if (skip_line_ff) begin
                  // Skip the rest of an overflowed line.
                  if (is_lf) begin
                     skip_line_in = 1'b0;
                  end
               end else if (is_lf && partial_len_ff == '0) begin
                  // Drop a lone line feed.
               end else if (fill_count_ff >= LW'(RING_DEPTH)
                            || (is_lf && queued_lines_ff >= CW'(LINE_SLOTS))) begin
                  // Discard the pending line.
                  write_ptr_in   = line_start_ff;
                  fill_count_in  = (fill_count_ff >= partial_len_ff)
                                 ? fill_count_ff - partial_len_ff : '0;
                  partial_len_in = '0;
                  dropped_in     = 1'b1;
                  if (fill_count_ff >= LW'(RING_DEPTH) && !is_lf) begin
                     skip_line_in = 1'b1;
                  end
               end else begin
                  mem_we         = 1'b1;
                  write_ptr_in   = ring_next(write_ptr_ff);
                  fill_count_in  = fill_count_ff + LW'(1);
                  partial_len_in = new_len;
                  if (is_lf) begin
                     lq_we           = 1'b1;
                     queue_tail_in   = slot_next(queue_tail_ff);
                     queued_lines_in = queued_lines_ff + CW'(1);
                     partial_len_in  = '0;
                     line_start_in   = ring_next(write_ptr_ff);
                  end
               end
            end
            ITEM_PULL: begin
               pend_in.valid   = 1'b1;
               pend_in.dropped = dropped_ff;
               pend_in.sel     = SEL_IMM;
               pend_in.imm     = 8'h00;
               if (frame_pos_ff == '0 && queued_lines_ff == '0) begin
                  pend_in.ok = 1'b0;
               end else begin
                  pend_in.ok   = 1'b1;
                  frame_pos_in = frame_pos_ff + FW'(1);
                  priority if (frame_pos_ff == FW'(0)) begin
                     pend_in.sel = SEL_START;
                     pend_in.imm = FRAME_START;
                  end else if (frame_pos_ff == FW'(1)) begin
                     pend_in.imm = 8'((frame_len & LEN_HI_MASK) >> 8);
                  end else if (frame_pos_ff == FW'(2)) begin
                     pend_in.imm = frame_len[7:0];
                  end else if (frame_pos_ff < FW'(HEADER_END)) begin
                     pend_in.sel = SEL_HDR;
                     pend_in.imm = cfg_regs[cfg_idx];
                  end else if (frame_pos_ff < FW'(HEADER_END) + FW'(cur_len)) begin
                     pend_in.sel   = SEL_PAY;
                     mem_re        = 1'b1;
                     read_ptr_in   = ring_next(read_ptr_ff);
                     fill_count_in = (fill_count_ff != '0)
                                   ? fill_count_ff - LW'(1) : '0;
                  end else begin
                     pend_in.sel     = SEL_SUM;
                     pend_in.last    = 1'b1;
                     queue_head_in   = slot_next(queue_head_ff);
                     queued_lines_in = (queued_lines_ff != '0)
                                     ? queued_lines_ff - CW'(1) : '0;
                     frame_pos_in    = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_ptr_ff    <= '0;
         read_ptr_ff     <= '0;
         line_start_ff   <= '0;
         fill_count_ff   <= '0;
         partial_len_ff  <= '0;
         queue_head_ff   <= '0;
         queue_tail_ff   <= '0;
         queued_lines_ff <= '0;
         frame_pos_ff    <= '0;
         dropped_ff      <= 1'b0;
         skip_line_ff    <= 1'b0;
         pend_ff         <= '0;
      end else begin
         write_ptr_ff    <= write_ptr_in;
         read_ptr_ff     <= read_ptr_in;
         line_start_ff   <= line_start_in;
         fill_count_ff   <= fill_count_in;
         partial_len_ff  <= partial_len_in;
         queue_head_ff   <= queue_head_in;
         queue_tail_ff   <= queue_tail_in;
         queued_lines_ff <= queued_lines_in;
         frame_pos_ff    <= frame_pos_in;
         dropped_ff      <= dropped_in;
         skip_line_ff    <= skip_line_in;
         pend_ff         <= pend_in;
      end
   end

   // Ring memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[write_ptr_ff] <= q_entry.data;
      end
      if (mem_re) begin
         mem_data_ff <= ring_mem[read_ptr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (lq_we) begin
         len_queue_ff[queue_tail_ff] <= new_len;
      end
   end

   `LFP_ASSERT(a_fill_bound, fill_count_ff <= LW'(RING_DEPTH), "ring fill above depth")
   `LFP_ASSERT(a_lines_bound, queued_lines_ff <= CW'(LINE_SLOTS), "line queue overrun")
   `LFP_ASSERT(a_partial_fits, partial_len_ff <= fill_count_ff, "pending line beyond fill")
   `LFP_ASSERT_IMPLY(a_frame_has_line, frame_pos_ff != '0, queued_lines_ff != '0,
      "frame active with no queued line")

endmodule

// ===== src/lfp_emit.sv =====
// Back end of the packetizer: checksum tracking and the result register.
// Depends on lfp_pkg.
module lfp_emit import lfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  result_type pend,
   input  logic [7:0] mem_data,
   output logic       pend_take,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_out_valid,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_frame_last,
   output logic       rsp_dropped_flag
);

   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_valid_ff;
   logic [7:0] out_byte_ff, out_byte_in;
   logic       last_ff;
   logic       dropped_ff;
   logic [7:0] sum_ff, sum_in;

   assign pend_take = pend.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      sum_in       = sum_ff;
      out_byte_in  = pend.imm;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (pend_take) begin
         rsp_valid_in = 1'b1;
         unique case (pend.sel)
            SEL_IMM: begin
            end
            SEL_START: begin
               sum_in = 8'h00;
            end
            SEL_HDR: begin
               sum_in = sum_ff + pend.imm;
            end
            SEL_PAY: begin
               out_byte_in = mem_data;
               sum_in      = sum_ff + mem_data;
            end
            SEL_SUM: begin
               out_byte_in = CHECK_BASE - sum_ff;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         sum_ff       <= 8'h00;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         sum_ff       <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_take) begin
         out_valid_ff <= pend.ok;
         out_byte_ff  <= out_byte_in;
         last_ff      <= pend.last;
         dropped_ff   <= pend.dropped;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_valid    = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_frame_last   = last_ff;
   assign rsp_dropped_flag = dropped_ff;

endmodule

// ===== src/line_to_frame_packetizer.sv =====
// Top level of the line-to-frame packetizer: header registers and the
// front, engine and emit stages. Depends on lfp_pkg and the lfp_* modules.
//
// Usage:
//   req channel: each item is either a push (opcode 0) carrying one received
//   byte, or a pull (opcode 1) asking for the next byte of the current frame.
//   Pushes build lines in a ring; a line feed closes a line. Pulls return
//   0x7E, a 16-bit big-endian length (payload + 5), the four header
//   registers, the payload with its line feed, then the checksum byte.
//   rsp channel: a pull gives exactly one item; a push gives none. With no
//   complete line a pull returns out_valid 0.
//   csr port: write the four header bytes while the block is idle.
//   Path: a pull accepted on req passes the input queue, the engine's pending
//   result register and the emit result register before rsp_valid rises.
//   Throughput: one item per cycle unless the receiver stalls, set by the
//   in-order single-ported engine and by at most one ring read per pull.
//   Receiver stall: the result register holds, the engine then the four-item
//   input queue fill, and req_stall rises once that queue is full.
//   Reset: pointers, counters, queue and the sticky drop flag clear; ring and
//   length storage are not cleared.
module line_to_frame_packetizer import lfp_pkg::*; #(
   parameter int RING_DEPTH = 512,
   parameter int LINE_SLOTS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_opcode,
   input  logic [7:0]        req_rx_byte,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_out_valid,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_frame_last,
   output logic              rsp_dropped_flag,
   input  logic              csr_write,
   input  logic [CFG_IW-1:0] csr_index,
   input  logic [7:0]        csr_data
);

   // Header registers: command, source, destination, payload type.
   logic [CFG_REGS-1:0][7:0] cfg_ff;

   logic            q_valid;
   logic            q_ready;
   queue_entry_type q_entry;
   result_type      pend;
   logic [7:0]      mem_data;
   logic            pend_take;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   // Accept and classify; pushed zero bytes stop here.
   lfp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .q_valid     (q_valid),
      .q_entry     (q_entry),
      .q_ready     (q_ready)
   );

   // Advance ring and frame state, one item per cycle unless a held result stalls it.
   lfp_engine #(
      .RING_DEPTH (RING_DEPTH),
      .LINE_SLOTS (LINE_SLOTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_ready   (q_ready),
      .cfg_regs  (cfg_ff),
      .pend      (pend),
      .mem_data  (mem_data),
      .pend_take (pend_take)
   );

   // Resolve payload bytes and checksum, hold the result under stall.
   lfp_emit u_emit (
      .clock            (clock),
      .reset            (reset),
      .pend             (pend),
      .mem_data         (mem_data),
      .pend_take        (pend_take),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_valid    (rsp_out_valid),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_frame_last   (rsp_frame_last),
      .rsp_dropped_flag (rsp_dropped_flag)
   );

endmodule
